@@ design/tlsc_pkg.sv @@
// shared widths, reset values and result types of the text line style checker
package tlsc_pkg;

   localparam int COLUMN_BITS_DEFAULT = 16;
   localparam int COUNT_BITS_DEFAULT  = 24;
   localparam int TAB_STOP_DEFAULT    = 8;

   localparam int INDEX_BITS = 24;
   localparam int TALLY_BITS = 16;
   localparam int LIMIT_BITS = 16;

   localparam logic [LIMIT_BITS-1:0] LINE_LIMIT_RESET = 16'd80;

   localparam logic KIND_LINE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic REG_LINE_LIMIT   = 1'b0;
   localparam logic REG_WARNING_MODE = 1'b1;

   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_FORM_FEED = 8'h0C;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   typedef struct packed {
      logic                  report_kind;
      logic [INDEX_BITS-1:0] line_index;
      logic [TALLY_BITS-1:0] unprintable_count;
      logic                  trailing_space;
      logic                  too_long;
      logic [TALLY_BITS-1:0] excess_columns;
      logic                  no_final_newline;
      logic [INDEX_BITS-1:0] blank_lines_at_end;
      logic [INDEX_BITS-1:0] error_total;
      logic                  fatal;
      logic                  last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

@@ design/tlsc_rsp_queue.sv @@
// three-entry response queue that takes up to two results per cycle
module tlsc_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  tlsc_pkg::push_type   push,
   input  logic                 rsp_stall,
   output tlsc_pkg::result_type head,
   output logic                 head_valid,
   output logic                 busy
);

   tlsc_pkg::result_type slot_ff [3];
   tlsc_pkg::result_type slot_in [3];
   logic [1:0]           count_ff;
   logic [1:0]           count_in;
   logic                 pop;
   logic [1:0]           base;

   always_comb begin
      pop  = (count_ff != 2'd0) && !rsp_stall;
      base = count_ff - 2'(pop);
      slot_in[0] = pop ? slot_ff[1] : slot_ff[0];
      slot_in[1] = pop ? slot_ff[2] : slot_ff[1];
      slot_in[2] = slot_ff[2];
      for (int i = 0; i < 3; i++) begin
         if (push.count != 2'd0 && 2'(i) == base) begin
            slot_in[i] = push.first;
         end
         if (push.count == 2'd2 && 2'(i) == base + 2'd1) begin
            slot_in[i] = push.second;
         end
      end
      count_in = base + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign head       = slot_ff[0];
   assign head_valid = (count_ff != 2'd0);
   assign busy       = (count_ff >= 2'd2);

endmodule

@@ design/text_line_style_checker_unit.sv @@
// text line style checker: per-byte column tracking with line and end-of-file reports
// a report is registered in the response queue and is offered on rsp_ once it reaches the queue head
// throughput: one request per cycle while req_stall is low; an end of file after an open line yields two reports
// req_stall rises while two or more reports wait in the three-entry response queue
// reset is synchronous and active high: all line and file state clears, the queue empties,
// line_limit returns to 80 and warning_mode to 0
module text_line_style_checker_unit #(
   parameter int COLUMN_BITS = tlsc_pkg::COLUMN_BITS_DEFAULT,
   parameter int COUNT_BITS  = tlsc_pkg::COUNT_BITS_DEFAULT,
   parameter int TAB_STOP    = tlsc_pkg::TAB_STOP_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_report_kind,
   output logic [23:0] rsp_line_index,
   output logic [15:0] rsp_unprintable_count,
   output logic        rsp_trailing_space,
   output logic        rsp_too_long,
   output logic [15:0] rsp_excess_columns,
   output logic        rsp_no_final_newline,
   output logic [23:0] rsp_blank_lines_at_end,
   output logic [23:0] rsp_error_total,
   output logic        rsp_fatal,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);

   localparam logic [7:0] CHAR_TILDE     = 8'h7E;

   localparam int PHASE_BITS = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
   localparam logic [63:0] COLUMN_MAX_WIDE = (64'd1 << COLUMN_BITS) - 64'd1;
   localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
   localparam logic [PHASE_BITS-1:0]  MAX_PHASE  = PHASE_BITS'(COLUMN_MAX_WIDE % TAB_STOP);
   localparam logic [PHASE_BITS-1:0]  LAST_PHASE = PHASE_BITS'(TAB_STOP - 1);
   localparam logic [tlsc_pkg::TALLY_BITS-1:0] TALLY_MAX = '1;

   logic [COLUMN_BITS-1:0]          column_ff, column_in;
   logic [PHASE_BITS-1:0]           phase_ff, phase_in;
   logic [tlsc_pkg::TALLY_BITS-1:0] tally_ff, tally_in;
   logic                            ends_space_ff, ends_space_in;
   logic                            has_space_ff, has_space_in;
   logic [COUNT_BITS-1:0]           line_count_ff, line_count_in;
   logic [COUNT_BITS-1:0]           blank_run_ff, blank_run_in;
   logic [COUNT_BITS-1:0]           error_count_ff, error_count_in;
   logic [tlsc_pkg::LIMIT_BITS-1:0] line_limit_ff;
   logic                            warning_mode_ff;

   logic                   accept;
   logic                   queue_busy;
   tlsc_pkg::push_type     push;
   tlsc_pkg::result_type   head;
   tlsc_pkg::result_type   line_rsp;
   tlsc_pkg::result_type   summary_rsp;

   logic [COLUMN_BITS:0]   tab_sum;
   logic [COLUMN_BITS-1:0] col_inc;
   logic [PHASE_BITS-1:0]  phase_inc;
   logic [32:0]            col_diff;
   logic                   too_long;
   logic [15:0]            excess;
   logic [2:0]             error_adds;
   logic [COUNT_BITS+2:0]  error_sum;
   logic [COUNT_BITS-1:0]  line_error;
   logic [COUNT_BITS-1:0]  line_count_inc;
   logic [COUNT_BITS-1:0]  blank_inc;
   logic                   open_line;
   logic [COUNT_BITS-1:0]  sum_lines;
   logic [COUNT_BITS-1:0]  sum_error_base;
   logic [COUNT_BITS-1:0]  sum_blank;
   logic [COUNT_BITS-1:0]  sum_error;
   logic [31:0]            line_count_wide;
   logic [31:0]            line_error_wide;
   logic [31:0]            sum_lines_wide;
   logic [31:0]            sum_blank_wide;
   logic [31:0]            sum_error_wide;

   assign accept    = req_valid && !req_stall;
   assign req_stall = queue_busy;

   always_comb begin
      tab_sum = (COLUMN_BITS+1)'(column_ff) + (COLUMN_BITS+1)'(TAB_STOP)
              - (COLUMN_BITS+1)'(phase_ff);
      col_inc   = (column_ff == COLUMN_MAX) ? COLUMN_MAX : column_ff + 1'b1;
      phase_inc = (column_ff == COLUMN_MAX) ? MAX_PHASE
                : ((phase_ff == LAST_PHASE) ? '0 : phase_ff + 1'b1);

      col_diff = 33'(column_ff) - 33'(line_limit_ff);
      too_long = (33'(column_ff) > 33'(line_limit_ff)) && has_space_ff;
      excess   = !too_long ? 16'd0 : ((col_diff > 33'h0FFFF) ? 16'hFFFF : col_diff[15:0]);

      error_adds = 3'(tally_ff != '0) + 3'(ends_space_ff) + 3'(too_long)
                 + 3'(req_end_of_file);
      error_sum  = (COUNT_BITS+3)'(error_count_ff) + (COUNT_BITS+3)'(error_adds);
      line_error = (error_sum > (COUNT_BITS+3)'(COUNT_MAX)) ? COUNT_MAX
                 : error_sum[COUNT_BITS-1:0];
      line_count_inc = (line_count_ff == COUNT_MAX) ? COUNT_MAX : line_count_ff + 1'b1;
      blank_inc      = (blank_run_ff == COUNT_MAX) ? COUNT_MAX : blank_run_ff + 1'b1;

      open_line      = (column_ff != '0);
      sum_lines      = open_line ? line_count_inc : line_count_ff;
      sum_error_base = open_line ? line_error : error_count_ff;
      sum_blank      = open_line ? '0 : blank_run_ff;
      sum_error      = (sum_blank == '0 || sum_error_base == COUNT_MAX) ? sum_error_base
                     : sum_error_base + 1'b1;

      line_count_wide = 32'(line_count_inc);
      line_error_wide = 32'(line_error);
      sum_lines_wide  = 32'(sum_lines);
      sum_blank_wide  = 32'(sum_blank);
      sum_error_wide  = 32'(sum_error);

      line_rsp.report_kind        = tlsc_pkg::KIND_LINE;
      line_rsp.line_index         = line_count_wide[23:0];
      line_rsp.unprintable_count  = tally_ff;
      line_rsp.trailing_space     = ends_space_ff;
      line_rsp.too_long           = too_long;
      line_rsp.excess_columns     = excess;
      line_rsp.no_final_newline   = req_end_of_file;
      line_rsp.blank_lines_at_end = '0;
      line_rsp.error_total        = line_error_wide[23:0];
      line_rsp.fatal              = 1'b0;
      line_rsp.last               = !req_end_of_file;

      summary_rsp.report_kind        = tlsc_pkg::KIND_SUMMARY;
      summary_rsp.line_index         = sum_lines_wide[23:0];
      summary_rsp.unprintable_count  = '0;
      summary_rsp.trailing_space     = 1'b0;
      summary_rsp.too_long           = 1'b0;
      summary_rsp.excess_columns     = '0;
      summary_rsp.no_final_newline   = 1'b0;
      summary_rsp.blank_lines_at_end = sum_blank_wide[23:0];
      summary_rsp.error_total        = sum_error_wide[23:0];
      summary_rsp.fatal              = (sum_error != '0) && !warning_mode_ff;
      summary_rsp.last               = 1'b1;
   end

   always_comb begin
      column_in      = column_ff;
      phase_in       = phase_ff;
      tally_in       = tally_ff;
      ends_space_in  = ends_space_ff;
      has_space_in   = has_space_ff;
      line_count_in  = line_count_ff;
      blank_run_in   = blank_run_ff;
      error_count_in = error_count_ff;
      push.count     = 2'd0;
      push.first     = line_rsp;
      push.second    = summary_rsp;
      if (accept) begin
         if (req_end_of_file) begin
            column_in      = '0;
            phase_in       = '0;
            tally_in       = '0;
            ends_space_in  = 1'b0;
            has_space_in   = 1'b0;
            line_count_in  = '0;
            blank_run_in   = '0;
            error_count_in = '0;
            if (open_line) begin
               push.count = 2'd2;
            end else begin
               push.count = 2'd1;
               push.first = summary_rsp;
            end
         end else begin
            unique case (req_text_byte)
               tlsc_pkg::CHAR_NEWLINE: begin
                  push.count     = 2'd1;
                  line_count_in  = line_count_inc;
                  error_count_in = line_error;
                  blank_run_in   = open_line ? '0 : blank_inc;
                  column_in      = '0;
                  phase_in       = '0;
                  tally_in       = '0;
                  ends_space_in  = 1'b0;
                  has_space_in   = 1'b0;
               end
               tlsc_pkg::CHAR_TAB: begin
                  if (tab_sum[COLUMN_BITS]) begin
                     column_in = COLUMN_MAX;
                     phase_in  = MAX_PHASE;
                  end else begin
                     column_in = tab_sum[COLUMN_BITS-1:0];
                     phase_in  = '0;
                  end
                  ends_space_in = 1'b1;
                  has_space_in  = 1'b1;
               end
               tlsc_pkg::CHAR_SPACE: begin
                  column_in     = col_inc;
                  phase_in      = phase_inc;
                  ends_space_in = 1'b1;
                  has_space_in  = 1'b1;
               end
               tlsc_pkg::CHAR_FORM_FEED: begin
                  column_in = col_inc;
                  phase_in  = phase_inc;
               end
               default: begin
                  if ((req_text_byte < tlsc_pkg::CHAR_SPACE || req_text_byte > CHAR_TILDE)
                      && tally_ff != TALLY_MAX) begin
                     tally_in = tally_ff + 1'b1;
                  end
                  column_in     = col_inc;
                  phase_in      = phase_inc;
                  ends_space_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff       <= '0;
         phase_ff        <= '0;
         tally_ff        <= '0;
         ends_space_ff   <= 1'b0;
         has_space_ff    <= 1'b0;
         line_count_ff   <= '0;
         blank_run_ff    <= '0;
         error_count_ff  <= '0;
         line_limit_ff   <= tlsc_pkg::LINE_LIMIT_RESET;
         warning_mode_ff <= 1'b0;
      end else begin
         column_ff      <= column_in;
         phase_ff       <= phase_in;
         tally_ff       <= tally_in;
         ends_space_ff  <= ends_space_in;
         has_space_ff   <= has_space_in;
         line_count_ff  <= line_count_in;
         blank_run_ff   <= blank_run_in;
         error_count_ff <= error_count_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               tlsc_pkg::REG_LINE_LIMIT:   line_limit_ff   <= csr_write_data;
               tlsc_pkg::REG_WARNING_MODE: warning_mode_ff <= csr_write_data[0];
               default:                    line_limit_ff   <= line_limit_ff;
            endcase
         end
      end
   end

   tlsc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .rsp_stall  (rsp_stall),
      .head       (head),
      .head_valid (rsp_valid),
      .busy       (queue_busy)
   );

   assign rsp_report_kind        = head.report_kind;
   assign rsp_line_index         = head.line_index;
   assign rsp_unprintable_count  = head.unprintable_count;
   assign rsp_trailing_space     = head.trailing_space;
   assign rsp_too_long           = head.too_long;
   assign rsp_excess_columns     = head.excess_columns;
   assign rsp_no_final_newline   = head.no_final_newline;
   assign rsp_blank_lines_at_end = head.blank_lines_at_end;
   assign rsp_error_total        = head.error_total;
   assign rsp_fatal              = head.fatal;
   assign rsp_last               = head.last;

endmodule

@@ design/tlsc_checker.sv @@
// port-level checks of the text line style checker and their bind
module tlsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_report_kind,
   input logic [23:0] rsp_line_index,
   input logic [15:0] rsp_unprintable_count,
   input logic        rsp_trailing_space,
   input logic        rsp_too_long,
   input logic [15:0] rsp_excess_columns,
   input logic        rsp_no_final_newline,
   input logic [23:0] rsp_blank_lines_at_end,
   input logic [23:0] rsp_error_total,
   input logic        rsp_fatal,
   input logic        rsp_last
);

   rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_index)
         && $stable(rsp_error_total) && $stable(rsp_report_kind) && $stable(rsp_last))
      else $error("stalled response changed");

   summary_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_kind |-> rsp_last && rsp_unprintable_count == 16'd0
         && !rsp_trailing_space && !rsp_too_long && rsp_excess_columns == 16'd0
         && !rsp_no_final_newline)
      else $error("summary carries line fields");

   line_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_kind |-> !rsp_fatal && rsp_blank_lines_at_end == 24'd0
         && (rsp_too_long || rsp_excess_columns == 16'd0))
      else $error("line report fields inconsistent");

   open_line_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_kind && rsp_no_final_newline |-> !rsp_last)
      else $error("unterminated line report marked last");

   line_errors_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_kind
         && (rsp_too_long || rsp_trailing_space || rsp_no_final_newline)
         |-> rsp_error_total != 24'd0)
      else $error("line fault without error count");

endmodule

bind text_line_style_checker_unit tlsc_checker u_tlsc_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for the text line style checker: directed and random files against a predictor
module tb_top;

   localparam logic [7:0] PRINTABLE_LOW  = 8'h20;
   localparam logic [7:0] PRINTABLE_HIGH = 8'h7E;

   localparam int DIRECTED_ROWS    = 23;
   localparam int PHASE_COUNT      = 8;
   localparam int PHASE_REQUESTS   = 110;
   localparam int LONG_LINE_LENGTH = 60;

   localparam tlsc_pkg::result_type NO_REPORT = '0;
   localparam tlsc_pkg::result_type EMPTY_SUMMARY = {tlsc_pkg::KIND_SUMMARY, 24'd0, 16'd0,
      1'b0, 1'b0, 16'd0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b1};
   localparam tlsc_pkg::result_type BLANK_LINE_ONE = {tlsc_pkg::KIND_LINE, 24'd1, 16'd0,
      1'b0, 1'b0, 16'd0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b1};
   localparam tlsc_pkg::result_type BLANK_LINE_TWO = {tlsc_pkg::KIND_LINE, 24'd2, 16'd0,
      1'b0, 1'b0, 16'd0, 1'b0, 24'd0, 24'd0, 1'b0, 1'b1};
   localparam tlsc_pkg::result_type TWO_BLANK_SUMMARY = {tlsc_pkg::KIND_SUMMARY, 24'd2, 16'd0,
      1'b0, 1'b0, 16'd0, 1'b0, 24'd2, 24'd1, 1'b1, 1'b1};

   typedef struct packed {
      logic [7:0]           text;
      logic                 eof;
      logic                 typed;
      tlsc_pkg::result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_text_byte;
   logic        req_end_of_file;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_report_kind;
   logic [23:0] rsp_line_index;
   logic [15:0] rsp_unprintable_count;
   logic        rsp_trailing_space;
   logic        rsp_too_long;
   logic [15:0] rsp_excess_columns;
   logic        rsp_no_final_newline;
   logic [23:0] rsp_blank_lines_at_end;
   logic [23:0] rsp_error_total;
   logic        rsp_fatal;
   logic        rsp_last;
   logic        csr_write_enable;
   logic        csr_index;
   logic [15:0] csr_write_data;

   tlsc_pkg::result_type expected_reports[$];
   tlsc_pkg::result_type seen_report;
   stim_row_type         directed_rows [DIRECTED_ROWS];

   // predicted checker state
   logic [15:0] limit_reg;
   logic        warn_reg;
   logic [15:0] cur_column;
   logic [15:0] cur_unprintable;
   logic        trailing_ws;
   logic        saw_ws;
   logic [23:0] lines_done;
   logic [23:0] empty_run;
   logic [23:0] err_count;

   bit sender_idle_on;
   bit receiver_idle_on;
   int hold_cycles = 0;
   int sent_count;
   int fail_count;

   text_line_style_checker_unit u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_text_byte          (req_text_byte),
      .req_end_of_file        (req_end_of_file),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_report_kind        (rsp_report_kind),
      .rsp_line_index         (rsp_line_index),
      .rsp_unprintable_count  (rsp_unprintable_count),
      .rsp_trailing_space     (rsp_trailing_space),
      .rsp_too_long           (rsp_too_long),
      .rsp_excess_columns     (rsp_excess_columns),
      .rsp_no_final_newline   (rsp_no_final_newline),
      .rsp_blank_lines_at_end (rsp_blank_lines_at_end),
      .rsp_error_total        (rsp_error_total),
      .rsp_fatal              (rsp_fatal),
      .rsp_last               (rsp_last),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   always #5 clock = ~clock;

   assign seen_report = {rsp_report_kind, rsp_line_index, rsp_unprintable_count,
                         rsp_trailing_space, rsp_too_long, rsp_excess_columns,
                         rsp_no_final_newline, rsp_blank_lines_at_end, rsp_error_total,
                         rsp_fatal, rsp_last};

   function automatic logic [15:0] sat16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [23:0] sat24(input logic [23:0] v);
      return (v == 24'hFFFFFF) ? v : v + 24'd1;
   endfunction

   function automatic void clear_line_state();
      cur_column      = '0;
      cur_unprintable = '0;
      trailing_ws     = 1'b0;
      saw_ws          = 1'b0;
   endfunction

   function automatic tlsc_pkg::result_type close_line(input logic no_newline);
      tlsc_pkg::result_type r;
      logic                 over;
      over = (cur_column > limit_reg) && saw_ws;
      lines_done = sat24(lines_done);
      if (no_newline) err_count = sat24(err_count);
      if (cur_unprintable != 0) err_count = sat24(err_count);
      if (trailing_ws) err_count = sat24(err_count);
      if (over) err_count = sat24(err_count);
      r = '0;
      r.report_kind       = tlsc_pkg::KIND_LINE;
      r.line_index        = lines_done;
      r.unprintable_count = cur_unprintable;
      r.trailing_space    = trailing_ws;
      r.too_long          = over;
      r.excess_columns    = over ? cur_column - limit_reg : 16'd0;
      r.no_final_newline  = no_newline;
      r.error_total       = err_count;
      empty_run = (cur_column == 0) ? sat24(empty_run) : 24'd0;
      clear_line_state();
      return r;
   endfunction

   function automatic void predict_request(input logic [7:0] text, input logic eof);
      tlsc_pkg::result_type r;
      int unsigned          next_stop;
      if (!eof) begin
         case (text)
            tlsc_pkg::CHAR_NEWLINE: begin
               r = close_line(1'b0);
               r.last = 1'b1;
               expected_reports.push_back(r);
            end
            tlsc_pkg::CHAR_TAB: begin
               next_stop = (cur_column / tlsc_pkg::TAB_STOP_DEFAULT + 1)
                         * tlsc_pkg::TAB_STOP_DEFAULT;
               cur_column = (next_stop > 32'hFFFF) ? 16'hFFFF : next_stop[15:0];
               trailing_ws = 1'b1;
               saw_ws = 1'b1;
            end
            tlsc_pkg::CHAR_SPACE: begin
               cur_column = sat16(cur_column);
               trailing_ws = 1'b1;
               saw_ws = 1'b1;
            end
            tlsc_pkg::CHAR_FORM_FEED: cur_column = sat16(cur_column);
            default: begin
               if (text < PRINTABLE_LOW || text > PRINTABLE_HIGH)
                  cur_unprintable = sat16(cur_unprintable);
               cur_column = sat16(cur_column);
               trailing_ws = 1'b0;
            end
         endcase
      end else begin
         if (cur_column != 0) begin
            r = close_line(1'b1);
            r.last = 1'b0;
            expected_reports.push_back(r);
         end
         if (empty_run != 0) err_count = sat24(err_count);
         r = '0;
         r.report_kind        = tlsc_pkg::KIND_SUMMARY;
         r.line_index         = lines_done;
         r.blank_lines_at_end = empty_run;
         r.error_total        = err_count;
         r.fatal              = (err_count != 0) && !warn_reg;
         r.last               = 1'b1;
         expected_reports.push_back(r);
         clear_line_state();
         lines_done = '0;
         empty_run  = '0;
         err_count  = '0;
      end
   endfunction

   task automatic push_request(input logic [7:0] text, input logic eof);
      if (sender_idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= text;
      req_end_of_file <= eof;
      do @(posedge clock); while (req_stall);
      predict_request(text, eof);
      sent_count++;
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_settings(input logic [15:0] limit, input logic warn);
      csr_write_enable <= 1'b1;
      csr_index        <= tlsc_pkg::REG_LINE_LIMIT;
      csr_write_data   <= limit;
      @(posedge clock);
      limit_reg = limit;
      csr_index      <= tlsc_pkg::REG_WARNING_MODE;
      csr_write_data <= {15'($urandom_range(0, 32767)), warn};
      @(posedge clock);
      warn_reg = warn;
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] random_text_byte();
      logic [7:0] c;
      case ($urandom_range(0, 19))
         12, 13: c = tlsc_pkg::CHAR_SPACE;
         14, 15: c = tlsc_pkg::CHAR_TAB;
         16: c = tlsc_pkg::CHAR_FORM_FEED;
         17: begin
            c = 8'($urandom_range(0, 31));
            if (c == tlsc_pkg::CHAR_TAB || c == tlsc_pkg::CHAR_NEWLINE
                || c == tlsc_pkg::CHAR_FORM_FEED) c = 8'h7F;
         end
         18: c = 8'($urandom_range(8'h7F, 8'hFF));
         19: c = 8'($urandom_range(0, 255));
         default: c = 8'($urandom_range(8'h21, PRINTABLE_HIGH));
      endcase
      return c;
   endfunction

   task automatic send_random_line();
      int length;
      case ($urandom_range(0, 9))
         0, 1: length = 0;
         2: length = $urandom_range(60, 140);
         default: length = $urandom_range(1, 24);
      endcase
      for (int i = 0; i < length; i++) push_request(random_text_byte(), 1'b0);
      if (length != 0 && $urandom_range(0, 3) == 0)
         push_request($urandom_range(0, 1) ? tlsc_pkg::CHAR_SPACE : tlsc_pkg::CHAR_TAB, 1'b0);
   endtask

   task automatic send_random_file();
      repeat ($urandom_range(0, 6)) begin
         send_random_line();
         push_request(tlsc_pkg::CHAR_NEWLINE, 1'b0);
      end
      if ($urandom_range(0, 2) == 0) send_random_line();
      push_request(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic show_report(input string tag, input tlsc_pkg::result_type r);
      $display("%s kind=%0d line=%0d unprintable=%0d trailing=%0d long=%0d excess=%0d", tag,
               r.report_kind, r.line_index, r.unprintable_count, r.trailing_space, r.too_long,
               r.excess_columns);
      $display("%s no_newline=%0d blank=%0d errors=%0d fatal=%0d last=%0d", tag,
               r.no_final_newline, r.blank_lines_at_end, r.error_total, r.fatal, r.last);
   endtask

   always @(posedge clock) begin
      if (!receiver_idle_on) begin
         rsp_stall   <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if ($urandom_range(0, 11) == 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) show_report("unexpected report:", seen_report);
         end else begin
            if (seen_report !== expected_reports[0]) begin
               fail_count++;
               if (fail_count <= 10) begin
                  show_report("mismatch expected:", expected_reports[0]);
                  show_report("mismatch actual:  ", seen_report);
               end
            end
            void'(expected_reports.pop_front());
         end
      end
   end

   initial begin
      #3_000_000;
      $display("text_line_style_checker_unit verification failed");
      $finish;
   end

   initial begin
      int start_count;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_text_byte    <= 8'h00;
      req_end_of_file  <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= tlsc_pkg::REG_LINE_LIMIT;
      csr_write_data   <= 16'h0000;
      sent_count       = 0;
      fail_count       = 0;
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
      limit_reg        = tlsc_pkg::LINE_LIMIT_RESET;
      warn_reg         = 1'b0;
      clear_line_state();
      lines_done = '0;
      empty_run  = '0;
      err_count  = '0;

      // fresh file summary, blank lines at end, every byte class, open last line
      directed_rows = '{
         {8'hFF, 1'b1, 1'b1, EMPTY_SUMMARY},
         {tlsc_pkg::CHAR_NEWLINE, 1'b0, 1'b1, BLANK_LINE_ONE},
         {tlsc_pkg::CHAR_NEWLINE, 1'b0, 1'b1, BLANK_LINE_TWO},
         {8'h00, 1'b1, 1'b1, TWO_BLANK_SUMMARY},
         {8'h41, 1'b0, 1'b0, NO_REPORT},
         {tlsc_pkg::CHAR_TAB, 1'b0, 1'b0, NO_REPORT},
         {8'h00, 1'b0, 1'b0, NO_REPORT},
         {8'hFF, 1'b0, 1'b0, NO_REPORT},
         {8'h7F, 1'b0, 1'b0, NO_REPORT},
         {tlsc_pkg::CHAR_SPACE, 1'b0, 1'b0, NO_REPORT},
         {tlsc_pkg::CHAR_FORM_FEED, 1'b0, 1'b0, NO_REPORT},
         {PRINTABLE_HIGH, 1'b0, 1'b0, NO_REPORT},
         {8'h1F, 1'b0, 1'b0, NO_REPORT},
         {8'h80, 1'b0, 1'b0, NO_REPORT},
         {tlsc_pkg::CHAR_SPACE, 1'b0, 1'b0, NO_REPORT},
         {tlsc_pkg::CHAR_NEWLINE, 1'b0, 1'b0, NO_REPORT},
         {tlsc_pkg::CHAR_TAB, 1'b0, 1'b0, NO_REPORT},
         {tlsc_pkg::CHAR_NEWLINE, 1'b0, 1'b0, NO_REPORT},
         {tlsc_pkg::CHAR_FORM_FEED, 1'b0, 1'b0, NO_REPORT},
         {tlsc_pkg::CHAR_NEWLINE, 1'b0, 1'b0, NO_REPORT},
         {8'h55, 1'b0, 1'b0, NO_REPORT},
         {8'h00, 1'b1, 1'b0, NO_REPORT},
         {tlsc_pkg::CHAR_NEWLINE, 1'b1, 1'b1, EMPTY_SUMMARY}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         push_request(directed_rows[i].text, directed_rows[i].eof);
         if (directed_rows[i].typed) begin
            void'(expected_reports.pop_back());
            expected_reports.push_back(directed_rows[i].want);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_quiet();
         case (phase)
            0: write_settings(16'd0, 1'b0);
            1: write_settings(16'hFFFF, 1'b1);
            2: write_settings(tlsc_pkg::LINE_LIMIT_RESET, 1'b0);
            3: write_settings(16'($urandom_range(8, 40)), 1'b1);
            4: write_settings(16'($urandom_range(0, 16)), 1'b0);
            5: write_settings(16'($urandom_range(20, 100)), 1'b1);
            6: write_settings(tlsc_pkg::LINE_LIMIT_RESET, 1'b1);
            default: write_settings(16'($urandom_range(0, 60)), 1'b0);
         endcase
         if (phase == 0) begin
            // one long line of unprintable bytes past a zero limit
            sender_idle_on = 1'b0;
            repeat (LONG_LINE_LENGTH) push_request(8'h01, 1'b0);
            push_request(tlsc_pkg::CHAR_TAB, 1'b0);
            push_request(tlsc_pkg::CHAR_NEWLINE, 1'b0);
            push_request(8'h00, 1'b1);
         end
         sender_idle_on   = (phase % 3 != 2) && (phase != PHASE_COUNT - 1);
         receiver_idle_on = (phase % 4 != 3) && (phase != PHASE_COUNT - 1);
         start_count = sent_count;
         while (sent_count - start_count < PHASE_REQUESTS) send_random_file();
      end

      wait_quiet();
      repeat (10) @(posedge clock);
      fail_count += expected_reports.size();
      if (fail_count == 0) begin
         $display("text_line_style_checker_unit verification clean");
      end else begin
         $display("text_line_style_checker_unit verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/tlsc_pkg.sv
design/tlsc_rsp_queue.sv
design/text_line_style_checker_unit.sv
design/tlsc_checker.sv
sim/tb_top.sv
